// ===== src/lu_pkg.sv =====
// Package with shared types and constants for the linear system solver.
`default_nettype none
package lu_pkg;
    typedef enum logic {
        t_meth_gauss = 1'b0,
        t_meth_crout = 1'b1
    } t_method;
    localparam int MAX_ORDER  = 8;
    localparam int DATA_WIDTH = 32;
    localparam int unsigned FRAC_BITS = 16;
    localparam logic [0:0] REG_ORDER  = 1'b0;
    localparam logic [0:0] REG_METHOD = 1'b1;
endpackage
`default_nettype wire

// ===== src/lu_linear_system_solver_top.sv =====
// Top level of the dense Q16.16 linear system solver (no pivoting).
//
//  channel | direction | handshake          | payload
//  s_axis  | in        | tvalid/tready      | tdata: coefficient[31:0]
//  m_axis  | out       | tvalid/tready      | tdata: unknown_index, solution_value
//          |           |                    | tuser: singular, tlast: last
//  cfg     | in        | write enable only  | index 0 order, 1 method
//
// Coefficients are loaded one item per cycle into the matrix RAM. The item that
// completes the N*(N+1) load starts a compute phase that runs a sequencer over
// the matrix RAM: read data and products are registered, and each division
// runs a bit-serial divider that the sequencer waits on. A solve takes roughly
// N^3/3 read-modify-writes plus roughly N^2 divisions.
// Results then leave one item per cycle through an output register while m_axis_tready is high.
// Reset is synchronous and active low; the matrix RAM needs no clearing.
// Input is not accepted during compute or while results are being drained.
`default_nettype none
module lu_linear_system_solver_top
    import lu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tdata: coefficient[DATA_WIDTH-1:0]
    input  wire logic [DATA_WIDTH-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: unknown_index[2:0], solution_value[34:3], zero fill
    output logic [39:0]                m_axis_tdata,
    // tuser: singular
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  i_cfg_we,
    input  wire logic                  i_cfg_index,
    input  wire logic [3:0]            i_cfg_data
);
    localparam int CELLS = MAX_ORDER * (MAX_ORDER + 1);
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(MAX_ORDER + 2);
    localparam int W2    = 2 * DATA_WIDTH;
    localparam int DCW   = $clog2(W2 + 1);
    localparam logic signed [W2-1:0] SAT_HI = W2'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [W2-1:0] SAT_LO = -SAT_HI - W2'(1);

    typedef enum logic [4:0] {
        S_LOAD, S_PIV_RD, S_PIV_W, S_F_RD, S_F_W, S_F_DIV, S_ROW_RD, S_ROW_RD2,
        S_ROW_MUL, S_ROW_WR, S_CR_RD, S_CR_W, S_CR_DIV, S_BS_RD, S_BS_PW,
        S_BS_BW, S_BS_DIV, S_BS_UR, S_BS_UW, S_BS_MUL, S_BS_DIV2, S_BS_ST,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [3:0]              r_order;
    t_method                 r_method;
    logic [6:0]              r_load_count;
    logic                    r_sing;
    logic [NW-1:0]           r_n, r_i, r_k, r_j;
    logic signed [DATA_WIDTH-1:0] r_piv, r_fac, r_a, r_x;
    logic signed [W2-1:0]    r_prod;
    logic signed [DATA_WIDTH-1:0] r_sol [MAX_ORDER];
    // divider
    logic [W2-1:0]           r_dq, r_drem;
    logic [DATA_WIDTH-1:0]   r_dd;
    logic [DCW-1:0]          r_dcnt;
    logic                    r_dneg;
    logic                    r_dbusy;

    logic                    ram_we;
    logic [AW-1:0]           ram_wa, ram_ra;
    logic [DATA_WIDTH-1:0]   ram_wd, ram_rd;

    lu_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CELLS)) u_mat (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic [NW-1:0] n_eff;
    always_comb begin
        if (r_order == 4'd0) n_eff = NW'(1);
        else if (32'(r_order) > MAX_ORDER) n_eff = NW'(MAX_ORDER);
        else n_eff = NW'(r_order);
    end

    function automatic logic [AW-1:0] addr(input logic [NW-1:0] r, input logic [NW-1:0] c,
                                           input logic [NW-1:0] n);
        logic [31:0] t;
        t = 32'(r) * (32'(n) + 32'd1) + 32'(c);
        if (t >= 32'(CELLS)) t = 32'(CELLS - 1);
        return AW'(t);
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [W2-1:0] v);
        if (v > SAT_HI) return SAT_HI[DATA_WIDTH-1:0];
        if (v < SAT_LO) return SAT_LO[DATA_WIDTH-1:0];
        return v[DATA_WIDTH-1:0];
    endfunction

    // Multiply result, truncated toward zero then saturated.
    logic signed [W2-1:0] prod_adj;
    logic signed [DATA_WIDTH-1:0] mul_q;
    always_comb begin
        prod_adj = r_prod;
        if (r_prod[W2-1]) prod_adj = r_prod + W2'((1 << FRAC_BITS) - 1);
        mul_q = sat(prod_adj >>> FRAC_BITS);
    end

    // Subtraction r_a - r_x, used by the row write state and by back substitution.
    logic signed [DATA_WIDTH-1:0] sub_q;
    assign sub_q = sat(W2'(r_a) - W2'(r_x));

    logic signed [W2-1:0] div_res;
    assign div_res = r_dneg ? -$signed(r_dq) : $signed(r_dq);

    logic in_acc, out_acc;
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD);

    always_comb begin
        ram_we = 1'b0;
        ram_wa = AW'(r_load_count);
        ram_wd = s_axis_tdata;
        ram_ra = addr(r_i, r_i, r_n);
        if (in_acc && 32'(r_load_count) < CELLS) ram_we = 1'b1;
        unique case (r_state)
            S_PIV_RD:  ram_ra = addr(r_i, r_i, r_n);
            S_F_RD:    ram_ra = addr(r_k, r_i, r_n);
            S_ROW_RD:  ram_ra = addr(r_i, r_j, r_n);
            S_ROW_RD2: ram_ra = addr(r_k, r_j, r_n);
            S_CR_RD:   ram_ra = addr(r_i, r_j, r_n);
            S_BS_RD:   ram_ra = addr(r_i, r_i, r_n);
            S_BS_PW:   ram_ra = addr(r_i, r_n, r_n);
            S_BS_UR:   ram_ra = addr(r_i, r_j, r_n);
            default:   ram_ra = addr(r_i, r_i, r_n);
        endcase
        if (r_state == S_ROW_WR) begin
            ram_we = 1'b1;
            ram_wa = addr(r_k, r_j, r_n);
            ram_wd = sub_q;
        end
        if (r_state == S_CR_DIV && !r_dbusy) begin
            ram_we = 1'b1;
            ram_wa = addr(r_i, r_j, r_n);
            ram_wd = r_x;
        end
    end

    // Divider start: a*65536 / b with signs handled separately.
    task automatic start_div(input logic signed [DATA_WIDTH-1:0] a,
                             input logic signed [DATA_WIDTH-1:0] b);
        logic [DATA_WIDTH-1:0] ma, mb;
        ma = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
        mb = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
        if (b == '0) begin
            r_sing <= 1'b1;
            r_x    <= '0;
        end else begin
            r_dbusy <= 1'b1;
            r_dcnt  <= DCW'(W2);
        end
        r_dq   <= W2'(ma) << FRAC_BITS;
        r_drem <= '0;
        r_dd   <= mb;
        r_dneg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_order      <= 4'd1;
            r_method     <= t_meth_gauss;
            r_load_count <= '0;
            r_sing       <= 1'b0;
            r_dbusy      <= 1'b0;
            m_axis_tvalid <= 1'b0;
            r_fac        <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ORDER) r_order <= i_cfg_data;
                else r_method <= t_method'(i_cfg_data[0]);
            end
            // bit-serial restoring divider on magnitudes
            if (r_dbusy) begin
                if (r_dcnt == '0) begin
                    r_dbusy <= 1'b0;
                    r_x <= sat(div_res);
                end else begin
                    logic [W2:0] t;
                    t = {r_drem, r_dq[W2-1]} - {1'b0, W2'(r_dd)};
                    if (!t[W2]) begin
                        r_drem <= t[W2-1:0];
                        r_dq   <= {r_dq[W2-2:0], 1'b1};
                    end else begin
                        r_drem <= {r_drem[W2-2:0], r_dq[W2-1]};
                        r_dq   <= {r_dq[W2-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                end
            end
            unique case (r_state)
                S_LOAD: if (in_acc) begin
                    if (32'(r_load_count) + 1 >= 32'(n_eff) * (32'(n_eff) + 1)) begin
                        r_load_count <= '0;
                        r_sing <= 1'b0;
                        r_n <= n_eff;
                        r_i <= '0;
                        r_state <= (n_eff == NW'(1) && r_method == t_meth_gauss)
                                   ? S_BS_RD : S_PIV_RD;
                    end else if (r_load_count < 7'd127) begin
                        r_load_count <= r_load_count + 7'd1;
                    end
                end
                S_PIV_RD: begin
                    if (r_method == t_meth_gauss && r_i + NW'(1) >= r_n) begin
                        r_i <= r_n - NW'(1);
                        r_state <= S_BS_RD;
                    end else begin
                        r_state <= S_PIV_W;
                    end
                end
                S_PIV_W: begin
                    r_piv <= ram_rd;
                    r_k <= r_i + NW'(1);
                    r_j <= r_i;
                    r_state <= (r_method == t_meth_crout) ? S_CR_RD : S_F_RD;
                end
                S_CR_RD: r_state <= S_CR_W;
                S_CR_W: begin
                    r_a <= ram_rd;
                    r_state <= S_CR_DIV;
                    start_div(ram_rd, r_piv);
                end
                S_CR_DIV: if (!r_dbusy) begin
                    if (r_j == r_n) begin
                        r_state <= S_F_RD;
                        r_j <= r_i;
                    end else begin
                        r_j <= r_j + NW'(1);
                        r_state <= S_CR_RD;
                    end
                end
                S_F_RD: begin
                    if (r_k >= r_n) begin
                        if (r_i + NW'(1) >= r_n) begin
                            r_i <= r_n - NW'(1);
                            r_state <= S_BS_RD;
                        end else begin
                            r_i <= r_i + NW'(1);
                            r_state <= S_PIV_RD;
                        end
                    end else r_state <= S_F_W;
                end
                S_F_W: begin
                    r_j <= r_i;
                    if (r_method == t_meth_crout) begin
                        r_fac <= ram_rd;
                        r_state <= S_ROW_RD;
                    end else begin
                        start_div(ram_rd, r_piv);
                        r_state <= S_F_DIV;
                    end
                end
                S_F_DIV: if (!r_dbusy) begin
                    r_fac <= r_x;
                    r_state <= S_ROW_RD;
                end
                S_ROW_RD: r_state <= S_ROW_RD2;
                S_ROW_RD2: begin
                    r_prod <= W2'(r_fac) * W2'($signed(ram_rd));
                    r_state <= S_ROW_MUL;
                end
                S_ROW_MUL: begin
                    r_a <= ram_rd;
                    r_x <= mul_q;
                    r_state <= S_ROW_WR;
                end
                S_ROW_WR: begin
                    if (r_j == r_n) begin
                        r_k <= r_k + NW'(1);
                        r_state <= S_F_RD;
                    end else begin
                        r_j <= r_j + NW'(1);
                        r_state <= S_ROW_RD;
                    end
                end
                S_BS_RD: r_state <= S_BS_PW;
                S_BS_PW: begin
                    r_piv <= ram_rd;
                    r_state <= S_BS_BW;
                end
                S_BS_BW: begin
                    start_div(ram_rd, r_piv);
                    r_j <= r_i + NW'(1);
                    r_state <= S_BS_DIV;
                end
                S_BS_DIV: if (!r_dbusy) begin
                    r_state <= (r_j >= r_n) ? S_BS_ST : S_BS_UR;
                end
                S_BS_UR: r_state <= S_BS_UW;
                S_BS_UW: begin
                    r_a <= r_x;
                    r_prod <= W2'($signed(ram_rd)) * W2'(r_sol[r_j[$clog2(MAX_ORDER)-1:0]]);
                    r_state <= S_BS_MUL;
                end
                S_BS_MUL: begin
                    start_div(mul_q, r_piv);
                    r_state <= S_BS_DIV2;
                end
                S_BS_DIV2: if (!r_dbusy) begin
                    r_x <= sub_q;
                    r_j <= r_j + NW'(1);
                    r_state <= (r_j + NW'(1) >= r_n) ? S_BS_ST : S_BS_UR;
                end
                S_BS_ST: begin
                    r_sol[r_i[$clog2(MAX_ORDER)-1:0]] <= r_x;
                    if (r_i == '0) begin
                        r_state <= S_OUT;
                        m_axis_tvalid <= 1'b0;
                    end else begin
                        r_i <= r_i - NW'(1);
                        r_state <= S_BS_RD;
                    end
                end
                S_OUT: begin
                    if (!m_axis_tvalid || out_acc) begin
                        if (m_axis_tvalid && m_axis_tlast) begin
                            m_axis_tvalid <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            m_axis_tvalid <= 1'b1;
                            m_axis_tdata <= {5'd0,
                                (r_sing ? DATA_WIDTH'(0) : r_sol[r_i[$clog2(MAX_ORDER)-1:0]]),
                                r_i[2:0]};
                            m_axis_tuser <= r_sing;
                            m_axis_tlast <= (r_i + NW'(1) == r_n);
                            r_i <= r_i + NW'(1);
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/lu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
